/* rtl/kabf_pkg.sv */
package kabf_pkg;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [30:0] ANGLE_NOISE_RESET = 31'd66;
  localparam logic [30:0] BIAS_NOISE_RESET = 31'd197;
  localparam logic [30:0] MEAS_NOISE_RESET = 31'd1966;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_M_DT_GB,
    ST_A_ANG,
    ST_M_DT_P11,
    ST_A_T1,
    ST_A_T2,
    ST_A_T3,
    ST_M_DT_T,
    ST_A_P00,
    ST_A_P01,
    ST_A_P10,
    ST_M_QB_DT,
    ST_A_P11,
    ST_A_S,
    ST_DIV0,
    ST_DIV1,
    ST_A_Y,
    ST_M_K0Y,
    ST_M_K1Y,
    ST_M_K0H00,
    ST_M_K0H01,
    ST_M_K1H00,
    ST_M_K1H01,
    ST_STORE,
    ST_OUT
  } kabf_state_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh000000007FFFFFFF) r = Q_MAX;
    else if (v < -64'sh0000000080000000) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) r = s[32] ? Q_MIN : Q_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) r = s[32] ? Q_MIN : Q_MAX;
    else r = s[31:0];
    return r;
  endfunction

endpackage

/* rtl/kalman_angle_bias_filter_core.sv */
// Two-state Kalman filter (angle and gyro bias) for up to AXES axes.
// Input transfers on s_axis carry the axis number in tuser and the measured
// angle, gyro rate and time step in tdata. Each input produces exactly one
// result transfer on m_axis with the axis in tuser and the new angle in tdata.
// An axis number of AXES or more changes no state and returns angle zero.
// The sequencer runs one shared 32x32 multiplier and one bit-serial divider.
// The two 48-step gain divisions dominate the time from input transfer to
// result valid. The block accepts a new item only once the previous result
// has been transferred; while the receiver stalls, the result holds on
// m_axis and s_axis_tready stays low.
// Configuration writes on the cfg channel are always accepted; indexes above
// two are ignored. Writes are to be made only while the block is idle.
// Reset (rst, synchronous) clears all filter state to zero and loads the
// default noise values.
module kalman_angle_bias_filter_core
  import kabf_pkg::*;
#(
  parameter int AXES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // measured_angle [31:0], gyro_rate [63:32], time_step [94:64], zero [95]
  input  logic [95:0] s_axis_tdata,
  // axis [0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // filtered_angle [31:0]
  output logic [31:0] m_axis_tdata,
  // result_axis [0]
  output logic        m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [30:0] qa, qb, rm;
  logic signed [31:0] st_ang [AXES];
  logic signed [31:0] st_bia [AXES];
  logic signed [31:0] st_p00 [AXES];
  logic signed [31:0] st_p01 [AXES];
  logic signed [31:0] st_p10 [AXES];
  logic signed [31:0] st_p11 [AXES];

  kabf_state_t state, state_next;
  logic        ax;
  logic        ax_ok;
  logic [AW-1:0] axi;
  logic signed [31:0] meas, gyro, dt;
  logic signed [31:0] ang, bia, p00, p01, p10, p11, t, s, k0, k1, y, h00, h01;
  logic signed [31:0] pm;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  logic signed [31:0] out_angle;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_den, div_q;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = out_angle;
  assign m_axis_tuser = ax;
  assign axi = AW'(ax);
  assign ax_ok = (32'(ax) < AXES);

  always_comb begin
    ma = dt;
    mb = t;
    case (state)
      ST_M_DT_GB: mb = qsub(gyro, bia);
      ST_M_DT_P11: mb = p11;
      ST_M_DT_T: mb = t;
      ST_A_P00: mb = p11;
      ST_M_QB_DT: begin ma = {1'b0, qb}; mb = dt; end
      ST_M_K0Y: begin ma = k0; mb = y; end
      ST_M_K1Y: begin ma = k1; mb = y; end
      ST_M_K0H00: begin ma = k0; mb = h00; end
      ST_M_K0H01: begin ma = k0; mb = h01; end
      ST_M_K1H00: begin ma = k1; mb = h00; end
      ST_M_K1H01: begin ma = k1; mb = h01; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mp <= ma * mb + 64'sd32768;
  end

  assign pm = sat64(mp >>> 16);

  assign div_num = (state == ST_A_S) ? p00 : p10;
  assign div_den = (state == ST_A_S) ? qadd(p00, {1'b0, rm}) : s;
  assign div_start = (state == ST_A_S) || (state == ST_DIV0 && div_done);

  kabf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_LOAD;
      ST_LOAD: state_next = ax_ok ? ST_M_DT_GB : ST_OUT;
      ST_M_DT_GB: state_next = ST_A_ANG;
      ST_A_ANG: state_next = ST_M_DT_P11;
      ST_M_DT_P11: state_next = ST_A_T1;
      ST_A_T1: state_next = ST_A_T2;
      ST_A_T2: state_next = ST_A_T3;
      ST_A_T3: state_next = ST_M_DT_T;
      ST_M_DT_T: state_next = ST_A_P00;
      ST_A_P00: state_next = ST_A_P01;
      ST_A_P01: state_next = ST_A_P10;
      ST_A_P10: state_next = ST_M_QB_DT;
      ST_M_QB_DT: state_next = ST_A_P11;
      ST_A_P11: state_next = ST_A_S;
      ST_A_S: state_next = ST_DIV0;
      ST_DIV0: if (div_done) state_next = ST_DIV1;
      ST_DIV1: if (div_done) state_next = ST_A_Y;
      ST_A_Y: state_next = ST_M_K0Y;
      ST_M_K0Y: state_next = ST_M_K1Y;
      ST_M_K1Y: state_next = ST_M_K0H00;
      ST_M_K0H00: state_next = ST_M_K0H01;
      ST_M_K0H01: state_next = ST_M_K1H00;
      ST_M_K1H00: state_next = ST_M_K1H01;
      ST_M_K1H01: state_next = ST_STORE;
      ST_STORE: state_next = ST_OUT;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= ANGLE_NOISE_RESET;
      qb <= BIAS_NOISE_RESET;
      rm <= MEAS_NOISE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_NOISE: qa <= cfg_data;
        REG_BIAS_NOISE: qb <= cfg_data;
        REG_MEAS_NOISE: rm <= cfg_data;
        default: ;
      endcase
    end
  end

  // The product of a multiply step is registered and consumed in the following step.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        ax <= s_axis_tuser;
        meas <= s_axis_tdata[31:0];
        gyro <= s_axis_tdata[63:32];
        dt <= {1'b0, s_axis_tdata[94:64]};
      end
      ST_LOAD: begin
        ang <= st_ang[axi];
        bia <= st_bia[axi];
        p00 <= st_p00[axi];
        p01 <= st_p01[axi];
        p10 <= st_p10[axi];
        p11 <= st_p11[axi];
        out_angle <= '0;
      end
      ST_A_ANG: ang <= qadd(ang, pm);
      ST_A_T1: t <= qsub(pm, p01);
      ST_A_T2: t <= qsub(t, p10);
      ST_A_T3: t <= qadd(t, {1'b0, qa});
      ST_M_DT_T: t <= pm;
      ST_A_P00: p00 <= qadd(p00, pm);
      ST_A_P01: begin
        t <= pm;
        p01 <= qsub(p01, pm);
      end
      ST_A_P10: p10 <= qsub(p10, t);
      ST_A_P11: p11 <= qadd(p11, pm);
      ST_A_S: s <= qadd(p00, {1'b0, rm});
      ST_DIV0: if (div_done) k0 <= div_q;
      ST_DIV1: if (div_done) k1 <= div_q;
      ST_A_Y: begin
        y <= qsub(meas, ang);
        h00 <= p00;
        h01 <= p01;
      end
      ST_M_K1Y: ang <= qadd(ang, pm);
      ST_M_K0H00: bia <= qadd(bia, pm);
      ST_M_K0H01: p00 <= qsub(p00, pm);
      ST_M_K1H00: p01 <= qsub(p01, pm);
      ST_M_K1H01: p10 <= qsub(p10, pm);
      ST_STORE: begin
        p11 <= qsub(p11, pm);
        out_angle <= ang;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        st_ang[i] <= '0;
        st_bia[i] <= '0;
        st_p00[i] <= '0;
        st_p01[i] <= '0;
        st_p10[i] <= '0;
        st_p11[i] <= '0;
      end
    end else if (state == ST_OUT && m_axis_tready && ax_ok) begin
      st_ang[axi] <= ang;
      st_bia[axi] <= bia;
      st_p00[axi] <= p00;
      st_p01[axi] <= p01;
      st_p10[axi] <= p10;
      st_p11[axi] <= p11;
    end
  end

endmodule

/* rtl/kabf_div.sv */
module kabf_div
  import kabf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic [47:0] rem;
  logic [47:0] dvd;
  logic [47:0] q;
  logic [31:0] dmag;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;
  logic [47:0] qs;
  logic signed [63:0] qv;

  assign trial = {rem, dvd[47]} - {17'd0, dmag};
  assign qs = q;
  assign qv = neg ? -$signed({16'd0, qs}) : $signed({16'd0, qs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rem <= '0;
        q <= '0;
        neg <= num[31] ^ den[31];
        dvd <= {(num[31] ? 32'(-num) : 32'(num)), 16'd0};
        dmag <= den[31] ? -den : den;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          q <= {q[46:0], 1'b1};
        end else begin
          rem <= {rem[46:0], dvd[47]};
          q <= {q[46:0], 1'b0};
        end
        dvd <= {dvd[46:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = (dmag == 32'd0) ? 32'sd0 : sat64(qv);

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

class kalman_scoreboard;
  logic signed [31:0] angle_st [2];
  logic signed [31:0] bias_st [2];
  logic signed [31:0] paa [2];
  logic signed [31:0] pab [2];
  logic signed [31:0] pba [2];
  logic signed [31:0] pbb [2];
  logic [30:0] noise_angle;
  logic [30:0] noise_bias;
  logic [30:0] noise_meas;
  logic [32:0] pending_q[$];
  int mismatches;

  function new();
    for (int i = 0; i < 2; i++) begin
      angle_st[i] = 0;
      bias_st[i] = 0;
      paa[i] = 0;
      pab[i] = 0;
      pba[i] = 0;
      pbb[i] = 0;
    end
    noise_angle = kabf_pkg::ANGLE_NOISE_RESET;
    noise_bias = kabf_pkg::BIAS_NOISE_RESET;
    noise_meas = kabf_pkg::MEAS_NOISE_RESET;
    mismatches = 0;
  endfunction

  function logic signed [31:0] clip(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function logic signed [31:0] add_q(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) + 66'(b);
    return clip(s);
  endfunction

  function logic signed [31:0] sub_q(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [65:0] s;
    s = 66'(a) - 66'(b);
    return clip(s);
  endfunction

  function logic signed [31:0] mul_q(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd32768;
    return clip(p >>> 16);
  endfunction

  function logic signed [31:0] div_q(logic signed [31:0] n, logic signed [31:0] d);
    logic signed [65:0] q;
    if (d == 0) return 0;
    q = (66'(n) <<< 16) / 66'(d);
    return clip(q);
  endfunction

  function void write_reg(logic [1:0] idx, logic [30:0] v);
    if (idx == kabf_pkg::REG_ANGLE_NOISE) noise_angle = v;
    else if (idx == kabf_pkg::REG_BIAS_NOISE) noise_bias = v;
    else if (idx == kabf_pkg::REG_MEAS_NOISE) noise_meas = v;
  endfunction

  function void note_input(logic ax, logic [95:0] d);
    logic signed [31:0] meas, gyro, dt, ang, bia, p00, p01, p10, p11, t, s, k0, k1, y, h0, h1;
    meas = d[31:0];
    gyro = d[63:32];
    dt = {1'b0, d[94:64]};
    ang = angle_st[ax];
    bia = bias_st[ax];
    p00 = paa[ax];
    p01 = pab[ax];
    p10 = pba[ax];
    p11 = pbb[ax];
    ang = add_q(ang, mul_q(dt, sub_q(gyro, bia)));
    t = add_q(sub_q(sub_q(mul_q(dt, p11), p01), p10), {1'b0, noise_angle});
    p00 = add_q(p00, mul_q(dt, t));
    t = mul_q(dt, p11);
    p01 = sub_q(p01, t);
    p10 = sub_q(p10, t);
    p11 = add_q(p11, mul_q({1'b0, noise_bias}, dt));
    s = add_q(p00, {1'b0, noise_meas});
    k0 = div_q(p00, s);
    k1 = div_q(p10, s);
    y = sub_q(meas, ang);
    ang = add_q(ang, mul_q(k0, y));
    bia = add_q(bia, mul_q(k1, y));
    h0 = p00;
    h1 = p01;
    p00 = sub_q(p00, mul_q(k0, h0));
    p01 = sub_q(p01, mul_q(k0, h1));
    p10 = sub_q(p10, mul_q(k1, h0));
    p11 = sub_q(p11, mul_q(k1, h1));
    angle_st[ax] = ang;
    bias_st[ax] = bia;
    paa[ax] = p00;
    pab[ax] = p01;
    pba[ax] = p10;
    pbb[ax] = p11;
    pending_q.push_back({ax, ang});
  endfunction

  function void check_result(logic ax, logic [31:0] angle);
    logic [32:0] exp_v;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result axis %0d angle %h", ax, angle);
      return;
    end
    exp_v = pending_q.pop_front();
    if (exp_v != {ax, angle}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected axis %0d angle %h, got axis %0d angle %h",
                 exp_v[32], exp_v[31:0], ax, angle);
    end
  endfunction
endclass

module tb;
  import kabf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  kalman_scoreboard filter_sb = new();
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  localparam int WATCHDOG_LIMIT = 20000;

  kalman_angle_bias_filter_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) filter_sb.check_result(m_axis_tuser, m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= (stall_phase % 7) < 3;
        2: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= (stall_phase % 160) > 120;
      endcase
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(logic ax, logic [31:0] meas, logic [31:0] gyro, logic [30:0] dt);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= ax;
    s_axis_tdata <= {1'b0, dt, gyro, meas};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    filter_sb.note_input(ax, {1'b0, dt, gyro, meas});
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 150)) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [30:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    filter_sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (filter_sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 200 << 16) - (100 << 16);
    endcase
  endfunction

  function automatic logic [30:0] pick_dt();
    case ($urandom_range(0, 7))
      0: return 31'h7FFFFFFF;
      1: return 31'd0;
      2: return 31'($urandom());
      default: return 31'($urandom_range(1, 1 << 14));
    endcase
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_item(1'($urandom_range(0, 1)), pick_value(), pick_value(), pick_dt());
        burst--;
        count--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(1'b0, 32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF);
    send_item(1'b1, 32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF);
    send_item(1'b0, 32'h0, 32'h0, 31'd0);
    send_item(1'b1, 32'h0001_0000, 32'hFFFF_0000, 31'd655);
    send_item(1'b0, 32'hFFFFFFFF, 32'h00000001, 31'd1);
    send_item(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'd65536);
    drain();
    write_cfg(REG_ANGLE_NOISE, 31'd0);
    write_cfg(REG_BIAS_NOISE, 31'd0);
    write_cfg(REG_MEAS_NOISE, 31'd0);
    write_cfg(2'd3, 31'h7FFFFFFF);
    send_item(1'b0, 32'h0, 32'h0, 31'd0);
    send_item(1'b0, 32'h0010_0000, 32'h0, 31'd100);
    send_item(1'b1, 32'h0, 32'h0, 31'd0);
    send_item(1'b1, 32'h80000000, 32'h80000000, 31'h7FFFFFFF);
    drain();
    write_cfg(REG_ANGLE_NOISE, 31'h7FFFFFFF);
    write_cfg(REG_BIAS_NOISE, 31'h7FFFFFFF);
    write_cfg(REG_MEAS_NOISE, 31'h7FFFFFFF);
    send_item(1'b0, 32'h7FFFFFFF, 32'h0, 31'd65536);
    send_item(1'b1, 32'h80000000, 32'h0, 31'h7FFFFFFF);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 4;
      if (ph == 5) begin
        write_cfg(REG_ANGLE_NOISE, ANGLE_NOISE_RESET);
        write_cfg(REG_BIAS_NOISE, BIAS_NOISE_RESET);
        write_cfg(REG_MEAS_NOISE, MEAS_NOISE_RESET);
      end else begin
        write_cfg(REG_ANGLE_NOISE, 31'($urandom_range(0, 2000)));
        write_cfg(REG_BIAS_NOISE, 31'($urandom()));
        write_cfg(REG_MEAS_NOISE,
                  31'($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000)));
      end
      random_phase(215);
      drain();
    end

    if (filter_sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
